FILE: rtl/core/pps_pkg.sv
`timescale 1ns / 1ps
// Package for the preemptive priority scheduler.
// Holds the operation codes, the fixed field widths and the sequencer states.
package pps_pkg;

  localparam int ID_W    = 16;
  localparam int BURST_W = 16;
  localparam int PRIO_W  = 8;
  localparam int WCNT_W  = 5;

  localparam logic OP_ARRIVE = 1'b0;
  localparam logic OP_TICK   = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_SHIFT,
    ST_FINISH
  } pps_state_t;

endpackage

FILE: rtl/core/preemptive_priority_scheduler_core.sv
`timescale 1ns / 1ps
// Preemptive priority scheduler core: age-ordered ready queue in one memory.
// Arrival: goes to the end of the queue, or is dropped when full. Tick (N = waiting count):
// on an empty queue the result word at once; else a scan of the queue memory (N reads),
// then on a dispatch a shift of the entries behind the chosen one (at most N - 1 reads), then the word.
// The single read port of the queue memory sets the tick time.
// Reset (rst_n low, synchronous): queue empty, nothing running, flags clear.
module preemptive_priority_scheduler_core
  import pps_pkg::*;
#(
  parameter int QUEUE_DEPTH   = 16,
  parameter int PRIORITY_BITS = 8
) (
  input  logic               clk,
  input  logic               rst_n,
  // input word
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_op,
  input  logic [ID_W-1:0]    in_task_id,
  input  logic [BURST_W-1:0] in_burst,
  input  logic [PRIO_W-1:0]  in_priority_req,
  // result word
  output logic               out_valid,
  input  logic               out_ready,
  output logic               out_running_valid,
  output logic [ID_W-1:0]    out_running_id,
  output logic               out_finished,
  output logic [WCNT_W-1:0]  out_waiting_count,
  output logic               out_overflow
);

  // Queue entries are kept packed from address 0 upwards in order of entry,
  // so the oldest waiting task is always at the lowest address. Removing an
  // entry shifts the younger ones down by one; a new entry goes at the end.
  localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam int PB = PRIORITY_BITS;
  localparam int EW = ID_W + BURST_W + PB;

  // entry layout: {id, remaining, priority}
  logic [EW-1:0] mem [QUEUE_DEPTH];
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [EW-1:0] mem_wdata;
  logic [AW-1:0] mem_raddr;
  logic [EW-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_data_r <= mem[mem_raddr];
  end

  // read word fields
  logic [ID_W-1:0]    rd_id;
  logic [BURST_W-1:0] rd_rem;
  logic [PB-1:0]      rd_pri;
  assign rd_id  = rd_data_r[EW-1 -: ID_W];
  assign rd_rem = rd_data_r[PB +: BURST_W];
  assign rd_pri = rd_data_r[PB-1:0];

  // priority as used inside: only the low PRIORITY_BITS count
  logic [PB-1:0] pri_in;
  generate
    if (PB <= PRIO_W) begin : g_pri_cut
      assign pri_in = in_priority_req[PB-1:0];
    end else begin : g_pri_ext
      assign pri_in = {{(PB-PRIO_W){1'b0}}, in_priority_req};
    end
  endgenerate

  // state
  pps_state_t         state_r, state_nxt;
  logic [CW-1:0]      count_r, count_nxt;
  logic [CW-1:0]      issue_r, issue_nxt;
  logic               rd_vld_r, rd_vld_nxt;
  logic [AW-1:0]      rd_idx_r, rd_idx_nxt;
  logic               preempt_r, preempt_nxt;
  logic               dropped_r, dropped_nxt;

  // running task
  logic               run_active_r, run_active_nxt;
  logic [ID_W-1:0]    run_id_r, run_id_nxt;
  logic [BURST_W-1:0] run_rem_r, run_rem_nxt;
  logic [PB-1:0]      run_pri_r, run_pri_nxt;

  // best candidate found by the scan
  logic [ID_W-1:0]    best_id_r, best_id_nxt;
  logic [BURST_W-1:0] best_rem_r, best_rem_nxt;
  logic [PB-1:0]      best_pri_r, best_pri_nxt;
  logic [AW-1:0]      best_pos_r, best_pos_nxt;

  // result word
  logic               out_valid_r, out_valid_nxt;
  logic               out_ran_r, out_ran_nxt;
  logic [ID_W-1:0]    out_id_r, out_id_nxt;
  logic               out_fin_r, out_fin_nxt;
  logic [CW-1:0]      out_cnt_r, out_cnt_nxt;
  logic               out_ovf_r, out_ovf_nxt;

  logic [CW-1:0]      cnt_m1;
  logic [BURST_W-1:0] rem_dec;
  assign cnt_m1  = count_r - 1'b1;
  assign rem_dec = (run_rem_r != '0) ? (run_rem_r - 1'b1) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      count_r      <= '0;
      issue_r      <= '0;
      rd_vld_r     <= 1'b0;
      preempt_r    <= 1'b0;
      dropped_r    <= 1'b0;
      run_active_r <= 1'b0;
      run_id_r     <= '0;
      run_rem_r    <= '0;
      run_pri_r    <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      count_r      <= count_nxt;
      issue_r      <= issue_nxt;
      rd_vld_r     <= rd_vld_nxt;
      preempt_r    <= preempt_nxt;
      dropped_r    <= dropped_nxt;
      run_active_r <= run_active_nxt;
      run_id_r     <= run_id_nxt;
      run_rem_r    <= run_rem_nxt;
      run_pri_r    <= run_pri_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    rd_idx_r   <= rd_idx_nxt;
    best_id_r  <= best_id_nxt;
    best_rem_r <= best_rem_nxt;
    best_pri_r <= best_pri_nxt;
    best_pos_r <= best_pos_nxt;
    out_ran_r  <= out_ran_nxt;
    out_id_r   <= out_id_nxt;
    out_fin_r  <= out_fin_nxt;
    out_cnt_r  <= out_cnt_nxt;
    out_ovf_r  <= out_ovf_nxt;
  end

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    issue_nxt      = issue_r;
    rd_vld_nxt     = 1'b0;
    rd_idx_nxt     = issue_r[AW-1:0];
    preempt_nxt    = preempt_r;
    dropped_nxt    = dropped_r;
    run_active_nxt = run_active_r;
    run_id_nxt     = run_id_r;
    run_rem_nxt    = run_rem_r;
    run_pri_nxt    = run_pri_r;
    best_id_nxt    = best_id_r;
    best_rem_nxt   = best_rem_r;
    best_pri_nxt   = best_pri_r;
    best_pos_nxt   = best_pos_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_ran_nxt    = out_ran_r;
    out_id_nxt     = out_id_r;
    out_fin_nxt    = out_fin_r;
    out_cnt_nxt    = out_cnt_r;
    out_ovf_nxt    = out_ovf_r;
    mem_we         = 1'b0;
    mem_waddr      = '0;
    mem_wdata      = '0;
    mem_raddr      = issue_r[AW-1:0];
    in_ready       = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (in_op == OP_ARRIVE) begin
            if (count_r == CW'(QUEUE_DEPTH)) begin
              dropped_nxt = 1'b1;
            end else begin
              mem_we    = 1'b1;
              mem_waddr = count_r[AW-1:0];
              mem_wdata = {in_task_id, in_burst, pri_in};
              count_nxt = count_r + 1'b1;
            end
          end else begin
            issue_nxt = '0;
            state_nxt = (count_r == '0) ? ST_FINISH : ST_SCAN;
          end
        end
      end

      ST_SCAN: begin
        // one read issued and one compared per cycle; strict greater keeps
        // the oldest among equal priorities
        if (issue_r < count_r) begin
          rd_vld_nxt = 1'b1;
          issue_nxt  = issue_r + 1'b1;
        end
        if (rd_vld_r) begin
          if (rd_idx_r == '0 || rd_pri > best_pri_r) begin
            best_id_nxt  = rd_id;
            best_rem_nxt = rd_rem;
            best_pri_nxt = rd_pri;
            best_pos_nxt = rd_idx_r;
          end
        end else if (issue_r == count_r) begin
          if (!run_active_r) begin
            preempt_nxt = 1'b0;
            issue_nxt   = CW'(best_pos_r) + 1'b1;
            state_nxt   = ST_SHIFT;
          end else if (best_pri_r > run_pri_r) begin
            preempt_nxt = 1'b1;
            issue_nxt   = CW'(best_pos_r) + 1'b1;
            state_nxt   = ST_SHIFT;
          end else begin
            state_nxt = ST_FINISH;
          end
        end
      end

      ST_SHIFT: begin
        // close the gap: entry k moves to k-1; reads run ahead of writes
        if (issue_r < count_r) begin
          rd_vld_nxt = 1'b1;
          issue_nxt  = issue_r + 1'b1;
        end
        if (rd_vld_r) begin
          mem_we    = 1'b1;
          mem_waddr = rd_idx_r - 1'b1;
          mem_wdata = rd_data_r;
        end else if (issue_r == count_r) begin
          if (preempt_r) begin
            // preempted task goes back in as the newest entry
            mem_we    = 1'b1;
            mem_waddr = cnt_m1[AW-1:0];
            mem_wdata = {run_id_r, run_rem_r, run_pri_r};
          end else begin
            count_nxt = cnt_m1;
          end
          run_active_nxt = 1'b1;
          run_id_nxt     = best_id_r;
          run_rem_nxt    = best_rem_r;
          run_pri_nxt    = best_pri_r;
          state_nxt      = ST_FINISH;
        end
      end

      ST_FINISH: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_ran_nxt   = run_active_r;
          out_id_nxt    = run_active_r ? run_id_r : '0;
          out_fin_nxt   = run_active_r && (rem_dec == '0);
          out_cnt_nxt   = count_r;
          out_ovf_nxt   = dropped_r;
          if (run_active_r) begin
            if (rem_dec == '0) begin
              run_active_nxt = 1'b0;
              run_id_nxt     = '0;
              run_pri_nxt    = '0;
              run_rem_nxt    = '0;
            end else begin
              run_rem_nxt = rem_dec;
            end
          end
          state_nxt = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign out_valid         = out_valid_r;
  assign out_running_valid = out_ran_r;
  assign out_running_id    = out_id_r;
  assign out_finished      = out_fin_r;
  assign out_overflow      = out_ovf_r;

  // waiting count is reported modulo 32
  generate
    if (CW >= WCNT_W) begin : g_wcnt_cut
      assign out_waiting_count = out_cnt_r[WCNT_W-1:0];
    end else begin : g_wcnt_ext
      assign out_waiting_count = {{(WCNT_W-CW){1'b0}}, out_cnt_r};
    end
  endgenerate

endmodule

FILE: tb/preemptive_priority_scheduler_core_test.sv
`timescale 1ns / 1ps
// Self-checking bench for preemptive_priority_scheduler_core.
// Needs pps_pkg and the core; carries its own scheduling predictor.
module preemptive_priority_scheduler_core_test;
  import pps_pkg::*;

  localparam int SLOTS      = 16;
  localparam int PRIO_BITS  = 8;
  localparam int RAND_WORDS = 1350;
  localparam int CYCLE_CAP  = 500000;
  localparam logic [PRIO_W-1:0] PRIO_MASK = PRIO_W'((1 << PRIO_BITS) - 1);

  // one pending input word; hold marks a pause until all results are in
  typedef struct {
    logic               hold;
    logic               op;
    logic [ID_W-1:0]    id;
    logic [BURST_W-1:0] burst;
    logic [PRIO_W-1:0]  prio;
  } sched_word_t;

  typedef struct {
    logic              running_valid;
    logic [ID_W-1:0]   running_id;
    logic              finished;
    logic [WCNT_W-1:0] waiting_count;
    logic              overflow;
  } tick_result_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic               in_op = OP_TICK;
  logic [ID_W-1:0]    in_task_id = '0;
  logic [BURST_W-1:0] in_burst = '0;
  logic [PRIO_W-1:0]  in_priority_req = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic               out_running_valid;
  logic [ID_W-1:0]    out_running_id;
  logic               out_finished;
  logic [WCNT_W-1:0]  out_waiting_count;
  logic               out_overflow;

  sched_word_t  word_q[$];            // words still to be offered
  tick_result_t tick_results_due[$];  // predicted tick results, oldest first
  int           mismatches = 0;
  int           words_taken = 0;
  int           sink_cyc = 0;
  int           hold_left = 0;
  int           cyc = 0;

  // predictor state: ready queue slots plus the running task
  logic [ID_W-1:0]    slot_id   [SLOTS];
  logic [BURST_W-1:0] slot_rem  [SLOTS];
  logic [PRIO_W-1:0]  slot_pri  [SLOTS];
  int                 slot_rank [SLOTS];
  bit                 slot_used [SLOTS];
  bit                 cur_active;
  logic [ID_W-1:0]    cur_id;
  logic [BURST_W-1:0] cur_rem;
  logic [PRIO_W-1:0]  cur_pri;
  bit                 lost_arrival;

  preemptive_priority_scheduler_core #(
    .QUEUE_DEPTH  (SLOTS),
    .PRIORITY_BITS(PRIO_BITS)
  ) dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_op            (in_op),
    .in_task_id       (in_task_id),
    .in_burst         (in_burst),
    .in_priority_req  (in_priority_req),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_running_valid(out_running_valid),
    .out_running_id   (out_running_id),
    .out_finished     (out_finished),
    .out_waiting_count(out_waiting_count),
    .out_overflow     (out_overflow)
  );

  always #1 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Scheduling predictor
  // ---------------------------------------------------------------------------
  function automatic int tasks_waiting();
    int n;
    n = 0;
    for (int k = 0; k < SLOTS; k++) if (slot_used[k]) n++;
    return n;
  endfunction

  // new entry always takes the youngest rank
  function automatic bit queue_task(logic [ID_W-1:0] id, logic [BURST_W-1:0] rem,
                                    logic [PRIO_W-1:0] pri);
    int n;
    n = tasks_waiting();
    for (int k = 0; k < SLOTS; k++) begin
      if (!slot_used[k]) begin
        slot_used[k] = 1'b1;
        slot_id[k]   = id;
        slot_rem[k]  = rem;
        slot_pri[k]  = pri;
        slot_rank[k] = n;
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  // highest priority wins, oldest rank breaks ties; -1 when empty
  function automatic int best_waiting();
    int b;
    b = -1;
    for (int k = 0; k < SLOTS; k++) begin
      if (!slot_used[k]) continue;
      if (b < 0 || slot_pri[k] > slot_pri[b] ||
          (slot_pri[k] == slot_pri[b] && slot_rank[k] < slot_rank[b]))
        b = k;
    end
    return b;
  endfunction

  // move a slot into the run position and close the gap in the ranks
  function automatic void dispatch_slot(int s);
    cur_active = 1'b1;
    cur_id     = slot_id[s];
    cur_rem    = slot_rem[s];
    cur_pri    = slot_pri[s];
    slot_used[s] = 1'b0;
    for (int k = 0; k < SLOTS; k++)
      if (slot_used[k] && slot_rank[k] > slot_rank[s]) slot_rank[k]--;
  endfunction

  task automatic schedule_word(logic op, logic [ID_W-1:0] id, logic [BURST_W-1:0] burst,
                               logic [PRIO_W-1:0] prio);
    tick_result_t res;
    int s;
    logic [ID_W-1:0]    pid;
    logic [BURST_W-1:0] prem;
    logic [PRIO_W-1:0]  ppri;
    if (op == OP_ARRIVE) begin
      if (!queue_task(id, burst, prio & PRIO_MASK)) lost_arrival = 1'b1;
      return;
    end
    res = '{1'b0, '0, 1'b0, '0, 1'b0};
    s = best_waiting();
    if (!cur_active) begin
      if (s >= 0) dispatch_slot(s);
    end else if (s >= 0 && slot_pri[s] > cur_pri) begin
      // preempted task goes back as the newest entry
      pid  = cur_id;
      prem = cur_rem;
      ppri = cur_pri;
      dispatch_slot(s);
      void'(queue_task(pid, prem, ppri));
    end
    if (cur_active) begin
      res.running_valid = 1'b1;
      res.running_id    = cur_id;
      if (cur_rem != 0) cur_rem--;
      if (cur_rem == 0) begin
        res.finished = 1'b1;
        cur_active   = 1'b0;
        cur_id       = '0;
        cur_pri      = '0;
      end
    end
    res.waiting_count = WCNT_W'(tasks_waiting());
    res.overflow      = lost_arrival;
    tick_results_due.push_back(res);
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic void add_word(logic op, logic [ID_W-1:0] id, logic [BURST_W-1:0] burst,
                                   logic [PRIO_W-1:0] prio);
    word_q.push_back('{1'b0, op, id, burst, prio});
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch at cycle %0d: %s got %0h want %0h", cyc, what, got, want);
    mismatches++;
  endtask

  // ---------------------------------------------------------------------------
  // Driver: offers the head of word_q; valid holds until the word is taken
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : drive
    bit busy;
    bit quiet;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      busy  = in_valid && !in_ready;
      quiet = (words_taken >= 600 && words_taken < 850);
      if (in_valid && in_ready) begin
        word_q.delete(0);
        words_taken++;
      end
      if (!busy) begin
        if (word_q.size() != 0 && word_q[0].hold) begin
          // pause: release once the last word is predicted and every result is back
          if (!in_valid && tick_results_due.size() == 0) word_q.delete(0);
          in_valid <= 1'b0;
        end else if (word_q.size() != 0 && (quiet || $urandom_range(0, 99) >= 12)) begin
          in_valid        <= 1'b1;
          in_op           <= word_q[0].op;
          in_task_id      <= word_q[0].id;
          in_burst        <= word_q[0].burst;
          in_priority_req <= word_q[0].prio;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: random stalls, one long hold-off, then a stretch always ready
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : sink
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      sink_cyc++;
      if (sink_cyc == 1000) hold_left = 600;
      if (hold_left != 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (sink_cyc >= 2000 && sink_cyc < 3500) begin
        out_ready <= 1'b1;
      end else begin
        out_ready <= ($urandom_range(0, 99) >= 12);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: predict on every accepted input word, check every result word
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : watch
    tick_result_t want;
    if (rst_n) begin
      if (in_valid && in_ready)
        schedule_word(in_op, in_task_id, in_burst, in_priority_req);
      if (out_valid && out_ready) begin
        if (tick_results_due.size() == 0) begin
          report_mismatch("unexpected result word, running_id", out_running_id, 0);
        end else begin
          want = tick_results_due.pop_front();
          if (out_running_valid !== want.running_valid)
            report_mismatch("running_valid", out_running_valid, want.running_valid);
          if (out_running_id !== want.running_id)
            report_mismatch("running_id", out_running_id, want.running_id);
          if (out_finished !== want.finished)
            report_mismatch("finished", out_finished, want.finished);
          if (out_waiting_count !== want.waiting_count)
            report_mismatch("waiting_count", out_waiting_count, want.waiting_count);
          if (out_overflow !== want.overflow)
            report_mismatch("overflow", out_overflow, want.overflow);
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin : watchdog
    cyc++;
    if (cyc == CYCLE_CAP) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus and end of run
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    int r;
    int k;
    int t;
    int next_pause;
    int rb;
    logic [BURST_W-1:0] b;
    logic [PRIO_W-1:0]  p;

    for (int i = 0; i < SLOTS; i++) slot_used[i] = 1'b0;
    cur_active   = 1'b0;
    cur_id       = '0;
    cur_rem      = '0;
    cur_pri      = '0;
    lost_arrival = 1'b0;

    // directed: idle tick on an empty queue
    add_word(OP_TICK, 16'h0000, 16'h0000, 8'h00);
    // zero burst at top priority: runs once and finishes at once
    add_word(OP_ARRIVE, 16'hFFFF, 16'h0000, 8'hFF);
    add_word(OP_TICK, 16'hFFFF, 16'hFFFF, 8'hFF);
    // longest burst at lowest priority, dispatched by the tick that follows
    add_word(OP_ARRIVE, 16'h0000, 16'hFFFF, 8'h00);
    add_word(OP_TICK, 16'h0000, 16'h0000, 8'h00);
    // higher priority preempts; the long task goes back as newest entry
    add_word(OP_ARRIVE, 16'h1234, 16'h0002, 8'h05);
    add_word(OP_TICK, 16'h0000, 16'h0000, 8'h00);
    // equal priority must not preempt
    add_word(OP_ARRIVE, 16'h2222, 16'h0001, 8'h05);
    add_word(OP_TICK, 16'h0000, 16'h0000, 8'h00);
    add_word(OP_TICK, 16'h0000, 16'h0000, 8'h00);
    // equal priorities leave in order of entry
    add_word(OP_ARRIVE, 16'h00A1, 16'h0001, 8'h03);
    add_word(OP_ARRIVE, 16'h00B2, 16'h0001, 8'h03);
    add_word(OP_TICK, 16'h0000, 16'h0000, 8'h00);
    add_word(OP_TICK, 16'h0000, 16'h0000, 8'h00);
    add_word(OP_TICK, 16'h0000, 16'h0000, 8'h00);

    // random: arrival batches followed by ticks, with floods and junk ticks
    next_pause = 450;
    while (word_q.size() < RAND_WORDS) begin
      if (word_q.size() >= next_pause) begin
        word_q.push_back('{1'b1, OP_TICK, '0, '0, '0});
        next_pause += 450;
      end
      r = $urandom_range(0, 99);
      if (r < 12) begin
        add_word(OP_TICK, ID_W'($urandom_range(0, 65535)),
                 BURST_W'($urandom_range(0, 65535)), PRIO_W'($urandom_range(0, 255)));
      end else begin
        k = (r < 22) ? $urandom_range(10, 20) : $urandom_range(1, 5);
        for (int i = 0; i < k; i++) begin
          rb = $urandom_range(0, 99);
          b  = (rb < 70) ? BURST_W'($urandom_range(0, 3)) :
               (rb < 95) ? BURST_W'($urandom_range(4, 20)) :
                           BURST_W'($urandom_range(0, 255));
          p  = ($urandom_range(0, 9) < 6) ? PRIO_W'($urandom_range(0, 7)) :
                                            PRIO_W'($urandom_range(0, 255));
          add_word(OP_ARRIVE, ID_W'($urandom_range(0, 65535)), b, p);
        end
        t = $urandom_range(1, 2 * k + 2);
        for (int i = 0; i < t; i++)
          add_word(OP_TICK, ID_W'($urandom_range(0, 65535)),
                   BURST_W'($urandom_range(0, 65535)), PRIO_W'($urandom_range(0, 255)));
      end
    end

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // sample on the falling edge, clear of the clocked processes
    while (word_q.size() != 0 || in_valid) @(negedge clk);
    while (tick_results_due.size() != 0) @(negedge clk);
    repeat (2 * SLOTS + 10) @(negedge clk);
    if (tick_results_due.size() != 0)
      report_mismatch("results never delivered", 0, tick_results_due.size());

    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/core/pps_pkg.sv
rtl/core/preemptive_priority_scheduler_core.sv
tb/preemptive_priority_scheduler_core_test.sv
